// ===== hdl/vdr_pkg.sv =====
package vdr_pkg;

   localparam int unsigned DefMaxVertices = 1024;
   localparam int unsigned DefIndexBits   = 20;
   localparam int unsigned KeyParts       = 3;
   localparam int unsigned FieldBits      = 20;
   localparam int unsigned OldBits        = 10;
   localparam int unsigned SlotBits       = 10;
   localparam int unsigned CountBits      = 11;

   localparam logic [1:0] MODE_VERTEX = 2'd0;
   localparam logic [1:0] MODE_REMAP  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_INSERT,
      ST_REMAP,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/vdr_key_match.sv =====
module vdr_key_match #(
   parameter int unsigned MAX_VERTICES = vdr_pkg::DefMaxVertices,
   parameter int unsigned INDEX_BITS   = vdr_pkg::DefIndexBits
) (
   input  logic                                                     clock,
   input  logic                                                     rd_en,
   input  logic [$clog2(MAX_VERTICES)-1:0]                          rd_addr,
   input  logic [vdr_pkg::KeyParts*INDEX_BITS-1:0]                  probe_key,
   input  logic                                                     wr_en,
   input  logic [$clog2(MAX_VERTICES)-1:0]                          wr_addr,
   output logic                                                     hit
);
   import vdr_pkg::*;

   localparam int unsigned KeyBits = KeyParts * INDEX_BITS;

   // Key memory: one distinct vertex key per slot, registered read.
   logic [KeyBits-1:0] key_mem [MAX_VERTICES];
   logic [KeyBits-1:0] rd_key_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= probe_key;
      end
      if (rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
      end
   end

   // The probe key is held steady by the caller through the whole search.
   assign hit = (rd_key_ff == probe_key);

endmodule

// ===== hdl/vertex_dedup_remap.sv =====
// Vertex welding and corner remapping. Each request carries a mode: a vertex
// request is looked up among the distinct keys of the current mesh by a linear
// scan of the key memory (one read port, each entry read and then compared), and
// a new vertex adds a write of its key. A remap request reads the redirection
// memory; clear and unused modes go straight to the response. One request is in
// work at a time; a new request is taken while the previous response still
// waits on rsp_ready.
// Every request produces exactly one response. No clearing pass follows reset:
// the memory contents are used only at entries written in the current mesh.
module vertex_dedup_remap #(
   parameter int unsigned MAX_VERTICES = vdr_pkg::DefMaxVertices,
   parameter int unsigned INDEX_BITS   = vdr_pkg::DefIndexBits
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_mode,
   input  logic [vdr_pkg::FieldBits-1:0]     req_position_index,
   input  logic [vdr_pkg::FieldBits-1:0]     req_normal_index,
   input  logic [vdr_pkg::FieldBits-1:0]     req_uv_index,
   input  logic [vdr_pkg::OldBits-1:0]       req_old_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_is_new,
   output logic [vdr_pkg::SlotBits-1:0]      rsp_slot_index,
   output logic [vdr_pkg::FieldBits-1:0]     rsp_kept_position,
   output logic [vdr_pkg::FieldBits-1:0]     rsp_kept_normal,
   output logic [vdr_pkg::FieldBits-1:0]     rsp_kept_uv,
   output logic [1:0]                        rsp_status,
   output logic [vdr_pkg::CountBits-1:0]     rsp_distinct_count
);
   import vdr_pkg::*;

   localparam int unsigned AddrBits = $clog2(MAX_VERTICES);
   localparam int unsigned CntBits  = $clog2(MAX_VERTICES + 1);
   localparam int unsigned KeyBits  = KeyParts * INDEX_BITS;
   localparam int unsigned KeepBits = (INDEX_BITS < FieldBits) ? INDEX_BITS : FieldBits;
   localparam int unsigned CmpBits  = (CntBits > OldBits) ? CntBits : OldBits;
   localparam logic [CntBits-1:0] MaxCount = CntBits'(MAX_VERTICES);

   state_type state_ff, state_in;

   logic [CntBits-1:0]  distinct_ff, distinct_in;
   logic [CntBits-1:0]  arrival_ff, arrival_in;
   logic [CntBits-1:0]  scan_ff, scan_in;
   logic [KeyBits-1:0]  key_ff;

   // Result being assembled for the current request.
   logic                res_new_ff;
   logic [AddrBits-1:0] res_slot_ff;
   logic                res_keep_ff;
   logic [1:0]          res_status_ff;

   logic [AddrBits-1:0] redirect_mem [MAX_VERTICES];
   logic [AddrBits-1:0] redirect_rd_ff;

   logic accept;
   logic out_free;
   logic hit;
   logic last_entry;
   logic key_rd_en;
   logic key_wr_en;
   logic redirect_wr_en;
   logic [AddrBits-1:0] redirect_wr_data;
   logic [KeyBits-1:0]  req_key;
   logic old_in_range;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid || rsp_ready;

   assign req_key = {INDEX_BITS'(req_uv_index[KeepBits-1:0]),
                     INDEX_BITS'(req_normal_index[KeepBits-1:0]),
                     INDEX_BITS'(req_position_index[KeepBits-1:0])};

   assign old_in_range = (CmpBits'(req_old_index) < CmpBits'(arrival_ff));
   assign last_entry   = ((scan_ff + 1'b1) == distinct_ff);

   vdr_key_match #(
      .MAX_VERTICES (MAX_VERTICES),
      .INDEX_BITS   (INDEX_BITS)
   ) u_key_match (
      .clock     (clock),
      .rd_en     (key_rd_en),
      .rd_addr   (scan_ff[AddrBits-1:0]),
      .probe_key (key_ff),
      .wr_en     (key_wr_en),
      .wr_addr   (distinct_ff[AddrBits-1:0]),
      .hit       (hit)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_mode == MODE_VERTEX) begin
                  if (arrival_ff >= MaxCount) begin
                     state_in = ST_DONE;
                  end else if (distinct_ff == '0) begin
                     state_in = ST_INSERT;
                  end else begin
                     state_in = ST_READ;
                  end
               end else if (req_mode == MODE_REMAP) begin
                  state_in = old_in_range ? ST_REMAP : ST_DONE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ:    state_in = ST_COMPARE;
         ST_COMPARE: begin
            priority if (hit) begin
               state_in = ST_DONE;
            end else if (last_entry) begin
               state_in = ST_INSERT;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_INSERT:  state_in = ST_DONE;
         ST_REMAP:   state_in = ST_DONE;
         ST_DONE:    state_in = out_free ? ST_IDLE : ST_DONE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Memory controls and counter updates.
   always_comb begin
      key_rd_en        = 1'b0;
      key_wr_en        = 1'b0;
      redirect_wr_en   = 1'b0;
      redirect_wr_data = scan_ff[AddrBits-1:0];
      distinct_in      = distinct_ff;
      arrival_in       = arrival_ff;
      scan_in          = scan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            if (accept && req_mode == MODE_CLEAR) begin
               distinct_in = '0;
               arrival_in  = '0;
            end
         end
         ST_READ: begin
            key_rd_en = 1'b1;
         end
         ST_COMPARE: begin
            if (hit) begin
               redirect_wr_en = 1'b1;
               arrival_in     = arrival_ff + 1'b1;
            end else if (!last_entry) begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_INSERT: begin
            key_wr_en        = 1'b1;
            redirect_wr_en   = 1'b1;
            redirect_wr_data = distinct_ff[AddrBits-1:0];
            distinct_in      = distinct_ff + 1'b1;
            arrival_in       = arrival_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         distinct_ff <= '0;
         arrival_ff  <= '0;
         scan_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         distinct_ff <= distinct_in;
         arrival_ff  <= arrival_in;
         scan_ff     <= scan_in;
      end
   end

   // Redirection memory: written at the arrival number, read at each accepted request for remaps.
   always_ff @(posedge clock) begin
      if (redirect_wr_en) begin
         redirect_mem[arrival_ff[AddrBits-1:0]] <= redirect_wr_data;
      end
      if (accept) begin
         redirect_rd_ff <= redirect_mem[AddrBits'(req_old_index)];
      end
   end

   // Result assembly. The key register doubles as the probe key for the scan.
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff        <= req_key;
         res_new_ff    <= 1'b0;
         res_slot_ff   <= '0;
         res_keep_ff   <= 1'b0;
         res_status_ff <= STATUS_OK;
         if (req_mode == MODE_VERTEX && arrival_ff >= MaxCount) begin
            res_status_ff <= STATUS_FULL;
         end else if (req_mode == MODE_REMAP && !old_in_range) begin
            res_status_ff <= STATUS_RANGE;
         end
      end
      if (state_ff == ST_COMPARE && hit) begin
         res_slot_ff <= scan_ff[AddrBits-1:0];
         res_keep_ff <= 1'b1;
      end
      if (state_ff == ST_INSERT) begin
         res_new_ff  <= 1'b1;
         res_slot_ff <= distinct_ff[AddrBits-1:0];
         res_keep_ff <= 1'b1;
      end
      if (state_ff == ST_REMAP) begin
         res_slot_ff <= redirect_rd_ff;
      end
   end

   // Output register: loaded at the end of a request, held until taken.
   logic rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_is_new         <= res_new_ff;
         rsp_slot_index     <= SlotBits'(res_slot_ff);
         rsp_status         <= res_status_ff;
         rsp_distinct_count <= CountBits'(distinct_ff);
         if (res_keep_ff) begin
            rsp_kept_position <= FieldBits'(key_ff[0 +: KeepBits]);
            rsp_kept_normal   <= FieldBits'(key_ff[INDEX_BITS +: KeepBits]);
            rsp_kept_uv       <= FieldBits'(key_ff[2*INDEX_BITS +: KeepBits]);
         end else begin
            rsp_kept_position <= '0;
            rsp_kept_normal   <= '0;
            rsp_kept_uv       <= '0;
         end
      end
   end

`ifndef SYNTHESIS
   a_distinct_le_arrival: assert property (@(posedge clock) disable iff (reset)
      distinct_ff <= arrival_ff)
      else $error("distinct count exceeds arrival count");

   a_arrival_bounded: assert property (@(posedge clock) disable iff (reset)
      arrival_ff <= MaxCount)
      else $error("arrival count beyond table depth");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode == MODE_CLEAR |=> arrival_ff == '0 && distinct_ff == '0)
      else $error("clear request did not reset the counters");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMPARE |-> scan_ff < distinct_ff)
      else $error("key scan ran past the kept entries");
`endif

endmodule

// ===== bench/vertex_dedup_remap_tb.sv =====
// Self-checking bench for the vertex welding and corner remapping block.
// A driver offers requests from a directed table, a full-table fill and then random meshes;
// a monitor runs a behavioral copy of the block on every accepted request and
// queues the expected response. Each accepted response is compared field by
// field with the oldest queued expectation.
module vertex_dedup_remap_tb;
   import vdr_pkg::*;

   localparam logic [1:0] ModeUnused = 2'd3;
   localparam int unsigned MaxVerts = DefMaxVertices;

   typedef struct packed {
      bit        is_new;
      bit [9:0]  slot;
      bit [19:0] kept_pos;
      bit [19:0] kept_nrm;
      bit [19:0] kept_uv;
      bit [1:0]  status;
      bit [10:0] count;
   } resp_t;

   typedef struct {
      logic [1:0]  mode;
      logic [19:0] pos;
      logic [19:0] nrm;
      logic [19:0] uv;
      logic [9:0]  old;
      bit          typed;
      resp_t       want;
   } row_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_mode;
   logic [19:0] req_position_index;
   logic [19:0] req_normal_index;
   logic [19:0] req_uv_index;
   logic [9:0]  req_old_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_is_new;
   logic [9:0]  rsp_slot_index;
   logic [19:0] rsp_kept_position;
   logic [19:0] rsp_kept_normal;
   logic [19:0] rsp_kept_uv;
   logic [1:0]  rsp_status;
   logic [10:0] rsp_distinct_count;

   vertex_dedup_remap DUT (.*);

   // Behavioral copy of the block's state.
   bit [59:0] weld_keys [MaxVerts];
   bit [9:0]  weld_redirect [MaxVerts];
   int unsigned weld_distinct;
   int unsigned weld_arrivals;

   resp_t pending_resps[$];
   int    errors;
   bit    req_taken;
   bit    cur_typed;
   resp_t cur_want;
   int    idle_pct;
   int    stall_pct;
   int    hold_cycles;
   int unsigned gen_arrivals;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #60000000;
      $display("vertex_dedup_remap_tb NOT OK");
      $finish;
   end

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   // Computes the response of one request and advances the welding state.
   function automatic resp_t weld_predict(logic [1:0] mode, logic [19:0] pos,
                                          logic [19:0] nrm, logic [19:0] uv,
                                          logic [9:0] old);
      resp_t r;
      bit [59:0] key;
      bit found;
      int unsigned slot;
      r = '0;
      found = 0;
      slot = 0;
      if (mode == MODE_VERTEX) begin
         if (weld_arrivals >= MaxVerts) begin
            r.status = STATUS_FULL;
         end else begin
            key = {uv, nrm, pos};
            for (int i = 0; i < weld_distinct; i++) begin
               if (!found && weld_keys[i] == key) begin
                  found = 1;
                  slot = i;
               end
            end
            if (!found) begin
               slot = weld_distinct;
               weld_keys[slot] = key;
               weld_distinct++;
            end
            weld_redirect[weld_arrivals] = 10'(slot);
            weld_arrivals++;
            r.is_new = !found;
            r.slot = 10'(slot);
            r.kept_pos = pos;
            r.kept_nrm = nrm;
            r.kept_uv = uv;
            r.status = STATUS_OK;
         end
      end else if (mode == MODE_REMAP) begin
         if (old >= weld_arrivals) begin
            r.status = STATUS_RANGE;
         end else begin
            r.slot = weld_redirect[old];
         end
      end else if (mode == MODE_CLEAR) begin
         weld_distinct = 0;
         weld_arrivals = 0;
      end
      r.count = 11'(weld_distinct);
      return r;
   endfunction

   // Monitor: both handshakes are sampled at the rising edge, before the
   // block's own updates of that edge take effect.
   always @(posedge clock) begin
      resp_t got;
      resp_t want;
      resp_t calc;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_is_new, rsp_slot_index, rsp_kept_position, rsp_kept_normal,
                 rsp_kept_uv, rsp_status, rsp_distinct_count};
         if (pending_resps.size() == 0) begin
            $display("response with no request waiting");
            errors++;
         end else begin
            want = pending_resps.pop_front();
            if (got.is_new !== want.is_new) report("is_new", got.is_new, want.is_new);
            if (got.slot !== want.slot) report("slot_index", got.slot, want.slot);
            if (got.kept_pos !== want.kept_pos)
               report("kept_position", got.kept_pos, want.kept_pos);
            if (got.kept_nrm !== want.kept_nrm)
               report("kept_normal", got.kept_nrm, want.kept_nrm);
            if (got.kept_uv !== want.kept_uv) report("kept_uv", got.kept_uv, want.kept_uv);
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.count !== want.count)
               report("distinct_count", got.count, want.count);
         end
      end
      if (!reset && req_valid && req_ready) begin
         calc = weld_predict(req_mode, req_position_index, req_normal_index,
                             req_uv_index, req_old_index);
         // A directed row with a typed response is checked against that value;
         // the predictor still runs so that its state follows the block.
         pending_resps.push_back(cur_typed ? cur_want : calc);
         req_taken = 1;
      end
   end

   // Receiver: a long hold-off counts down first, otherwise random stalls.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready = 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_ready = 1'b0;
         hold_cycles--;
      end else begin
         rsp_ready = ($urandom_range(99) >= stall_pct);
      end
   end

   // Offers one request, idling first at random, and returns at the falling
   // edge after it was accepted. Valid stays high across back-to-back requests.
   task automatic send(logic [1:0] mode, logic [19:0] pos, logic [19:0] nrm,
                       logic [19:0] uv, logic [9:0] old, bit typed = 0,
                       resp_t want = '0);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_mode = mode;
      req_position_index = pos;
      req_normal_index = nrm;
      req_uv_index = uv;
      req_old_index = old;
      cur_typed = typed;
      cur_want = want;
      req_valid = 1'b1;
      req_taken = 0;
      do @(negedge clock); while (!req_taken);
      if (mode == MODE_VERTEX && gen_arrivals < MaxVerts) gen_arrivals++;
      if (mode == MODE_CLEAR) gen_arrivals = 0;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending_resps.size() != 0) @(negedge clock);
   endtask

   // One random mesh: a pool of keys gives plenty of repeats, with some fresh
   // keys, corner remaps mostly within range, and a little noise.
   task automatic random_mesh(int n);
      logic [59:0] pool [$];
      logic [59:0] k;
      int sel;
      logic [9:0] old;
      if ($urandom_range(3) != 0)
         send(MODE_CLEAR, 20'($urandom), 20'($urandom), 20'($urandom), 10'($urandom));
      repeat ($urandom_range(1, 10)) pool.push_back(60'({$urandom, $urandom}));
      repeat (n) begin
         sel = $urandom_range(99);
         if (sel < 55) begin
            if ($urandom_range(4) == 0) k = 60'({$urandom, $urandom});
            else k = pool[$urandom_range(pool.size() - 1)];
            send(MODE_VERTEX, k[19:0], k[39:20], k[59:40], 10'($urandom));
         end else if (sel < 90) begin
            if ($urandom_range(9) == 0) old = 10'($urandom);
            else old = 10'($urandom_range(gen_arrivals + 1));
            send(MODE_REMAP, 20'($urandom), 20'($urandom), 20'($urandom), old);
         end else if (sel < 96) begin
            send(ModeUnused, 20'($urandom), 20'($urandom), 20'($urandom), 10'($urandom));
         end else begin
            send(MODE_CLEAR, 20'($urandom), 20'($urandom), 20'($urandom), 10'($urandom));
         end
      end
   endtask

   // Fills the redirection table with a few repeated keys, then runs into the
   // full table and remaps the last corner and the first.
   task automatic fill_table();
      logic [59:0] k;
      send(MODE_CLEAR, 0, 0, 0, 0);
      repeat (MaxVerts) begin
         case ($urandom_range(2))
            0: k = '0;
            1: k = '1;
            default: k = 60'h5a5a5a5a5a5a5a5;
         endcase
         send(MODE_VERTEX, k[19:0], k[39:20], k[59:40], 10'($urandom));
      end
      repeat (3)
         send(MODE_VERTEX, 20'($urandom), 20'($urandom), 20'($urandom), 10'($urandom));
      send(MODE_REMAP, 0, 0, 0, 10'h3ff);
      send(MODE_REMAP, 0, 0, 0, 10'h000);
   endtask

   initial begin
      row_t rows [$];
      localparam logic [19:0] M = 20'hfffff;
      errors = 0;
      idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 0;
      gen_arrivals = 0;
      weld_distinct = 0;
      weld_arrivals = 0;
      req_taken = 0;
      cur_typed = 0;
      cur_want = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_CLEAR;
      req_position_index = '0;
      req_normal_index = '0;
      req_uv_index = '0;
      req_old_index = '0;
      rsp_ready = 1'b0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed table; responses are typed in where obvious.
      rows = '{
         '{MODE_REMAP,  0, 0, 0, 0,     1, '{0, 0, 0, 0, 0, STATUS_RANGE, 0}},
         '{MODE_VERTEX, 0, 0, 0, 10'h3ff, 1, '{1, 0, 0, 0, 0, STATUS_OK, 1}},
         '{MODE_VERTEX, M, M, M, 0,     1, '{1, 1, M, M, M, STATUS_OK, 2}},
         '{MODE_VERTEX, 0, 0, 0, 0,     1, '{0, 0, 0, 0, 0, STATUS_OK, 2}},
         '{MODE_REMAP,  M, M, M, 0,     1, '{0, 0, 0, 0, 0, STATUS_OK, 2}},
         '{MODE_REMAP,  0, 0, 0, 1,     1, '{0, 1, 0, 0, 0, STATUS_OK, 2}},
         '{MODE_REMAP,  0, 0, 0, 2,     1, '{0, 0, 0, 0, 0, STATUS_OK, 2}},
         '{MODE_REMAP,  0, 0, 0, 3,     1, '{0, 0, 0, 0, 0, STATUS_RANGE, 2}},
         '{MODE_REMAP,  0, 0, 0, 10'h3ff, 1, '{0, 0, 0, 0, 0, STATUS_RANGE, 2}},
         '{ModeUnused,  M, M, M, 10'h3ff, 1, '{0, 0, 0, 0, 0, STATUS_OK, 2}},
         '{MODE_VERTEX, M, 0, 0, 0,     1, '{1, 2, M, 0, 0, STATUS_OK, 3}},
         '{MODE_VERTEX, 0, M, 0, 0,     1, '{1, 3, 0, M, 0, STATUS_OK, 4}},
         '{MODE_VERTEX, 0, 0, M, 0,     1, '{1, 4, 0, 0, M, STATUS_OK, 5}},
         '{MODE_VERTEX, M, 0, 0, 0,     0, '0},
         '{MODE_VERTEX, 20'h12345, 20'h6789a, 20'hbcdef, 0, 0, '0},
         '{MODE_REMAP,  0, 0, 0, 6,     0, '0},
         '{MODE_REMAP,  0, 0, 0, 5,     0, '0},
         '{MODE_CLEAR,  M, M, M, 10'h3ff, 1, '{0, 0, 0, 0, 0, STATUS_OK, 0}},
         '{MODE_REMAP,  0, 0, 0, 0,     1, '{0, 0, 0, 0, 0, STATUS_RANGE, 0}},
         '{MODE_VERTEX, M, M, M, 0,     1, '{1, 0, M, M, M, STATUS_OK, 1}},
         '{MODE_REMAP,  0, 0, 0, 0,     1, '{0, 0, 0, 0, 0, STATUS_OK, 1}},
         '{MODE_REMAP,  0, 0, 0, 1,     1, '{0, 0, 0, 0, 0, STATUS_RANGE, 1}}
      };
      foreach (rows[i])
         send(rows[i].mode, rows[i].pos, rows[i].nrm, rows[i].uv, rows[i].old,
              rows[i].typed, rows[i].want);

      // Full table without idling, where it runs fastest.
      fill_table();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 65; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 65; end
            default: begin idle_pct = 25; stall_pct = 25; end
         endcase
         // Hold the receiver off so the block fills and stalls its input.
         if (phase == 2) hold_cycles = 400;
         // Let the block empty completely before the last phase.
         if (phase == 3) drain();
         repeat (8) random_mesh($urandom_range(5, 35));
      end

      drain();
      repeat (100) @(negedge clock);
      if (errors == 0 && pending_resps.size() == 0) begin
         $display("vertex_dedup_remap_tb OK");
      end else begin
         $display("vertex_dedup_remap_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== vertex_dedup_remap.f =====
hdl/vdr_pkg.sv
hdl/vdr_key_match.sv
hdl/vertex_dedup_remap.sv
bench/vertex_dedup_remap_tb.sv
